// ===== hdl/tf512_pkg.sv =====
// package: types, constants and helper functions for the threefish-512 encrypt pipeline
package tf512_pkg;

    localparam int unsigned WordW    = 64;
    localparam int unsigned NumWords = 8;
    localparam int unsigned NumRnds  = 72;
    localparam int unsigned NumSkeys = 19;
    localparam int unsigned IdxW     = 3;
    localparam logic [63:0] KeyParity = 64'h1BD11BDAA9FC1A22;

    typedef logic [WordW-1:0] word_t;
    typedef word_t [NumWords-1:0] block_t;
    typedef word_t [NumWords:0] key_t;
    typedef word_t [2:0] twk_t;

    typedef struct packed {
        block_t v;
        twk_t   t;
    } stage_t;

    function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] j);
        logic [5:0] res;
        res = 6'd0;
        case ({r, j})
            5'd0:  res = 6'd46; 5'd1:  res = 6'd36; 5'd2:  res = 6'd19; 5'd3:  res = 6'd37;
            5'd4:  res = 6'd33; 5'd5:  res = 6'd27; 5'd6:  res = 6'd14; 5'd7:  res = 6'd42;
            5'd8:  res = 6'd17; 5'd9:  res = 6'd49; 5'd10: res = 6'd36; 5'd11: res = 6'd39;
            5'd12: res = 6'd44; 5'd13: res = 6'd9;  5'd14: res = 6'd54; 5'd15: res = 6'd56;
            5'd16: res = 6'd39; 5'd17: res = 6'd30; 5'd18: res = 6'd34; 5'd19: res = 6'd24;
            5'd20: res = 6'd13; 5'd21: res = 6'd50; 5'd22: res = 6'd10; 5'd23: res = 6'd17;
            5'd24: res = 6'd25; 5'd25: res = 6'd29; 5'd26: res = 6'd39; 5'd27: res = 6'd43;
            5'd28: res = 6'd8;  5'd29: res = 6'd35; 5'd30: res = 6'd56; 5'd31: res = 6'd22;
            default: res = 6'd0;
        endcase
        return res;
    endfunction

    function automatic word_t rotl(input word_t v, input logic [5:0] n);
        logic [2*WordW-1:0] dbl;
        dbl = {v, v} << n;
        return dbl[2*WordW-1 -: WordW];
    endfunction

    // one mix round followed by the word permutation
    function automatic block_t mix_round(input block_t v, input logic [2:0] r);
        block_t f;
        block_t o;
        for (int j = 0; j < 4; j++)
        begin
            f[2*j]   = v[2*j] + v[2*j+1];
            f[2*j+1] = rotl(v[2*j+1], rot_amt(r, j[1:0])) ^ f[2*j];
        end
        o[0] = f[2]; o[1] = f[1]; o[2] = f[4]; o[3] = f[7];
        o[4] = f[6]; o[5] = f[5]; o[6] = f[0]; o[7] = f[3];
        return o;
    endfunction

    // x mod 9 for x below 27, by compare and subtract
    function automatic logic [3:0] mod9(input logic [4:0] x);
        logic [4:0] r;
        r = x;
        if (r >= 5'd18)
            r = r - 5'd18;
        else if (r >= 5'd9)
            r = r - 5'd9;
        return r[3:0];
    endfunction

    // x mod 3 for x below 27
    function automatic logic [1:0] mod3(input logic [4:0] x);
        logic [3:0] r;
        r = mod9(x);
        if (r >= 4'd6)
            r = r - 4'd6;
        else if (r >= 4'd3)
            r = r - 4'd3;
        return r[1:0];
    endfunction

    function automatic block_t add_skey(input block_t v, input key_t k, input twk_t t,
                                        input logic [4:0] s);
        block_t o;
        for (int i = 0; i < NumWords; i++)
            o[i] = v[i] + k[mod9(s + 5'(i))];
        o[5] = o[5] + t[mod3(s)];
        o[6] = o[6] + t[mod3(s + 5'd1)];
        o[7] = o[7] + word_t'(s);
        return o;
    endfunction

endpackage

// ===== hdl/tf512_stage.sv =====
// module: one pipeline stage of four rounds with its subkey injection
module tf512_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        skey_idx,
    input  logic              stall,
    input  tf512_pkg::key_t   key,
    input  logic              in_valid,
    input  tf512_pkg::stage_t in_data,
    output logic              out_valid,
    output tf512_pkg::stage_t out_data
);
    import tf512_pkg::*;

    stage_t data_next;
    stage_t data_reg;
    logic   valid_reg;
    block_t v0, v1, v2, v3;

    always_comb
    begin
        v0 = add_skey(in_data.v, key, in_data.t, skey_idx);
        v1 = mix_round(v0, {skey_idx[0], 2'd0});
        v2 = mix_round(v1, {skey_idx[0], 2'd1});
        v3 = mix_round(v2, {skey_idx[0], 2'd2});
        data_next.v = mix_round(v3, {skey_idx[0], 2'd3});
        data_next.t = in_data.t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== hdl/threefish512_block_encrypt.sv =====
// module: threefish-512 block encryption, fully unrolled round pipeline
//
//  channel   | dir | fields (tdata, lowest bit first)
//  s_axis    | in  | plain_word_0..7, tweak_low, tweak_high (640 bits)
//  m_axis    | out | cipher_word_0..7 (512 bits)
//  cfg       | in  | cfg_we, cfg_index (key word 0..7), cfg_data
//
// one transaction per cycle sustained while m_axis is not stalled; the unrolled round
// pipeline is 18 four-round stages plus the final subkey stage
// reset clears all valid bits and the key registers (key all zero)
// a stall on m_axis freezes the whole pipeline in place: nothing lost or repeated
// s_axis_tready follows m_axis_tready or an empty output slot
module threefish512_block_encrypt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [639:0] s_axis_tdata,  // plain_word_0..7, tweak_low, tweak_high
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [511:0] m_axis_tdata,  // cipher_word_0..7
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import tf512_pkg::*;

    word_t  key_reg [NumWords];
    key_t   key;
    logic   stall;
    logic   vld [NumSkeys];
    stage_t dat [NumSkeys];
    logic   out_valid_reg;
    block_t out_data_reg;

    // key registers; parity word formed here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we)
            key_reg[cfg_index] <= cfg_data;
    end

    always_comb
    begin
        key[8] = KeyParity;
        for (int i = 0; i < NumWords; i++)
        begin
            key[i] = key_reg[i];
            key[8] = key[8] ^ key_reg[i];
        end
    end

    // pipeline moves whenever the output slot is free or being taken
    assign stall         = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !stall;

    assign vld[0]       = s_axis_tvalid;
    assign dat[0].v     = s_axis_tdata[511:0];
    assign dat[0].t[0]  = s_axis_tdata[575:512];
    assign dat[0].t[1]  = s_axis_tdata[639:576];
    assign dat[0].t[2]  = s_axis_tdata[575:512] ^ s_axis_tdata[639:576];

    // eighteen stages of subkey plus four rounds
    for (genvar s = 0; s < NumSkeys - 1; s++)
    begin : g_stage
        tf512_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .skey_idx  (5'(s)),
            .stall     (stall),
            .key       (key),
            .in_valid  (vld[s]),
            .in_data   (dat[s]),
            .out_valid (vld[s+1]),
            .out_data  (dat[s+1])
        );
    end

    // final subkey injection into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!stall)
            out_valid_reg <= vld[NumSkeys-1];
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
            out_data_reg <= add_skey(dat[NumSkeys-1].v, key, dat[NumSkeys-1].t, 5'd18);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule

// ===== hdl/tf512_checker.sv =====
// module: port-level checks for the threefish-512 encrypt block, with bind
module tf512_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [511:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind threefish512_block_encrypt tf512_checker u_tf512_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tf512_encrypt_checker.sv =====
// checker: predicts threefish-512 ciphertext for each accepted block and compares results
module tf512_encrypt_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [639:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [511:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SchedParity = 64'h1BD11BDAA9FC1A22;

    logic [63:0]  key_words [8];
    logic [511:0] cipher_queue [$];

    function automatic logic [63:0] rot_left(input logic [63:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (64 - n)));
    endfunction

    // full 72-round encryption of one block under the current key
    function automatic logic [511:0] encrypt_block(input logic [639:0] blk);
        int          rots [8][4];
        int          perm [8];
        logic [63:0] k [9];
        logic [63:0] t [3];
        logic [63:0] v [8];
        logic [63:0] f [8];
        logic [511:0] res;
        rots = '{'{46, 36, 19, 37}, '{33, 27, 14, 42}, '{17, 49, 36, 39}, '{44, 9, 54, 56},
                 '{39, 30, 34, 24}, '{13, 50, 10, 17}, '{25, 29, 39, 43}, '{8, 35, 56, 22}};
        perm = '{2, 1, 4, 7, 6, 5, 0, 3};
        k[8] = SchedParity;
        for (int i = 0; i < 8; i++)
        begin
            k[i] = key_words[i];
            k[8] ^= key_words[i];
            v[i] = blk[64*i +: 64];
        end
        t[0] = blk[512 +: 64];
        t[1] = blk[576 +: 64];
        t[2] = t[0] ^ t[1];
        for (int d = 0; d <= 72; d++)
        begin
            if (d % 4 == 0)
            begin
                // subkey injection every four rounds
                for (int i = 0; i < 8; i++)
                    v[i] += k[(d / 4 + i) % 9];
                v[5] += t[(d / 4) % 3];
                v[6] += t[(d / 4 + 1) % 3];
                v[7] += 64'(d / 4);
            end
            if (d == 72)
                break;
            for (int j = 0; j < 4; j++)
            begin
                f[2*j] = v[2*j] + v[2*j+1];
                f[2*j+1] = rot_left(v[2*j+1], rots[d % 8][j]) ^ f[2*j];
            end
            for (int i = 0; i < 8; i++)
                v[i] = f[perm[i]];
        end
        for (int i = 0; i < 8; i++)
            res[64*i +: 64] = v[i];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [511:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                key_words[i] <= '0;
            fail_count = 0;
            pending_count = cipher_queue.size();
        end
        else
        begin
            // outputs first: a result never belongs to the block accepted this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: %h", m_axis_tdata);
                end
                else
                begin
                    want = cipher_queue.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (want[64*i +: 64] !== m_axis_tdata[64*i +: 64])
                        begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("cipher_word_%0d mismatch: expected %h got %h",
                                         i, want[64*i +: 64], m_axis_tdata[64*i +: 64]);
                        end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                cipher_queue.push_back(encrypt_block(s_axis_tdata));
            if (cfg_we)
                key_words[cfg_index] <= cfg_data;
            pending_count = cipher_queue.size();
        end
    end
endmodule

// ===== dv/tb_threefish512_block_encrypt.sv =====
// testbench top: stimulus, key phases and verdict for the threefish-512 encrypt pipeline
module tb_threefish512_block_encrypt;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [639:0] s_axis_tdata;  // plain_word_0..7, tweak_low, tweak_high
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [511:0] m_axis_tdata;  // cipher_word_0..7
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    int           fail_count;
    int           pending_count;
    bit           long_hold;     // asks the receiver for one long stall

    localparam int PipeDepth = 19;

    threefish512_block_encrypt DUT (.*);

    tf512_encrypt_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = 64'h8000_0000_0000_0000;
            3: w = 64'h1;
            default: ;
        endcase
        return w;
    endfunction

    // receiver: random stall per transaction, plus one long hold-off on request
    initial
    begin
        int wait_cycles;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (120) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_cycles = $urandom_range(0, 4);
            if (wait_cycles == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one block, after a random gap unless no_gap is set, and wait for acceptance
    task automatic send_block(input logic [639:0] blk, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (PipeDepth + 2) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] kw [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= kw[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [639:0] rand_block();
        logic [639:0] b;
        for (int i = 0; i < 10; i++)
            b[64*i +: 64] = rand_word();
        return b;
    endfunction

    initial
    begin
        logic [63:0] kw [8];
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        long_hold     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encryption under the all-zero reset key, field extremes, then random blocks
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block({10{64'h8000_0000_0000_0000}}, 1'b0);
        send_block({10{64'h1}}, 1'b0);
        send_block({{2{64'h0}}, {8{64'hffff_ffff_ffff_ffff}}}, 1'b0);
        send_block({{2{64'hffff_ffff_ffff_ffff}}, {8{64'h0}}}, 1'b0);
        for (int i = 0; i < 4; i++)
            send_block(rand_block(), 1'b0);
        drain_results();

        // all-ones key, with field extremes and random blocks
        for (int i = 0; i < 8; i++)
            kw[i] = '1;
        write_key(kw);
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        for (int i = 0; i < 4; i++)
            send_block(rand_block(), 1'b0);
        drain_results();

        // six phases, each with a new key (random, the last all zero); one phase forces backpressure
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int i = 0; i < 8; i++)
                kw[i] = (ph == 5) ? 64'h0 : rand_word();
            write_key(kw);
            if (ph == 1)
                long_hold = 1'b1;
            for (int n = 0; n < 225; n++)
                send_block(rand_block(), ph == 1 && n < 60);
            // sender pause until everything has come back
            drain_results();
        end

        drain_results();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
